// ===== rtl/arpt_pkg.sv =====
// Shared types and constants of the read pileup tally.
// Used by the top level aligned_read_pileup_tally; no dependencies.
`default_nettype none
package arpt_pkg;

	localparam int LANES  = 4;
	localparam int CNT_W  = 32;
	localparam int QSUM_W = 40;
	localparam int RPSUM_W = 48;

	// item kinds
	localparam logic [1:0] ACT_HEADER = 2'd0;
	localparam logic [1:0] ACT_BASE   = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// expanded cigar ops that do not consume reference
	localparam logic [1:0] CIGAR_INS  = 2'd1;
	localparam logic [1:0] CIGAR_SOFT = 2'd2;

	localparam logic [1:0] CLASS_USABLE = 2'd0;

	localparam logic [2:0]  BASE_N      = 3'd4;
	localparam logic [7:0]  QUAL_OFFSET = 8'd33;
	localparam logic [11:0] FLAG_LIMIT  = 12'd256;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_QUAL = 2'd0;
	localparam logic [1:0] REG_MAP_QUAL  = 2'd1;
	localparam logic [1:0] REG_LEFT_TRIM = 2'd2;
	localparam logic [1:0] REG_RIGHT_TRIM = 2'd3;

	typedef struct packed {
		logic [RPSUM_W-1:0] rp_sum;
		logic [QSUM_W-1:0]  qual_sum;
		logic [CNT_W-1:0]   count;
	} tally_t;

	// one memory row holds the four bases of one reference position
	typedef tally_t [LANES-1:0] tally_row_t;

endpackage
`default_nettype wire

// ===== rtl/arpt_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none
module arpt_ram #(
	parameter int WIDTH = 480,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/aligned_read_pileup_tally.sv =====
// Top level of the read pileup tally: read filter, base window and row RMW.
// Depends on arpt_pkg and arpt_ram.
`default_nettype none
// Takes a read header, then one item per base in expanded-CIGAR order, and
// keeps per-position, per-base counts, quality sums and read-position sums in
// one row-wide memory (one row of four base lanes per reference position).
// After reset the memory is cleared one row per clock, with in_stall high;
// configuration writes are taken meanwhile. After that one item is accepted
// per clock: a tallied base reads its row at the transfer and writes it back
// in the next cycle, with a forwarding register covering a read of the row
// written at that same edge. A query reads the row into stage 1, then loads
// its result into the output register unless a stalled result sits there; the
// input stalls only while a query result waits behind a stalled output.
module aligned_read_pileup_tally #(
	parameter int POSITIONS = 65536,
	parameter int READ_MAX  = 1023
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] position,
	input  wire logic [11:0] flag_value,
	input  wire logic [7:0]  map_quality,
	input  wire logic [1:0]  alignment_class,
	input  wire logic [9:0]  left_clip,
	input  wire logic [9:0]  right_clip,
	input  wire logic [9:0]  read_length,
	input  wire logic        reverse_orientation,
	input  wire logic [2:0]  base_code,
	input  wire logic [7:0]  quality_char,
	input  wire logic [1:0]  cigar_op,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] base_count,
	output      logic [39:0] quality_sum,
	output      logic [47:0] read_position_sum,
	output      logic [2:0]  consensus_base
);
	import arpt_pkg::*;

	localparam int AW    = $clog2(POSITIONS);
	localparam int ROW_W = $bits(tally_row_t);

	// configuration
	logic [5:0] bqt_q;
	logic [7:0] mqt_q;
	logic [9:0] ltrim_q;
	logic [9:0] rtrim_q;

	// current read
	logic [15:0] read_start_q;
	logic        read_ok_q;
	logic [9:0]  base_offset_q;
	logic [9:0]  aligned_count_q;
	logic [9:0]  lc_q;
	logic [9:0]  rc_q;
	logic [9:0]  len_q;
	logic        rev_q;

	// clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// stage 1: row read returned
	logic          base_vld_s1;
	logic          qry_vld_s1;
	logic [AW-1:0] addr_s1;
	logic [1:0]    lane_s1;
	logic [7:0]    qadd_s1;
	logic [9:0]    rpadd_s1;
	logic          qok_s1;
	logic [2:0]    qbase_s1;

	// forwarding
	logic       fwd_hit_q;
	tally_row_t fwd_row_q;

	// output register
	logic        out_valid_q;
	logic [31:0] base_count_q;
	logic [39:0] quality_sum_q;
	logic [47:0] rp_sum_q;
	logic [2:0]  consensus_q;

	logic             in_acc;
	logic             is_hdr;
	logic             is_base;
	logic             is_qry;
	logic             base_live;
	logic             aligned_op;
	logic [16:0]      ref_pos;
	logic             qual_ok;
	logic [10:0]      win_lo;
	logic [11:0]      hi_sum;
	logic             tally;
	logic [9:0]       offset_inc;
	logic [9:0]       rp_val;
	logic             qry_ok;
	logic             hdr_ok;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	tally_row_t       row_rd;
	tally_row_t       wr_row;
	tally_t           cur;
	tally_t           q_cur;
	logic [40:0]      qs_full;
	logic [48:0]      rp_full;
	logic             pa_sel;
	logic             pb_sel;
	logic [31:0]      pa_cnt;
	logic [31:0]      pb_cnt;
	logic             top_sel;
	logic [1:0]       best_idx;
	logic [31:0]      best_cnt;
	logic             out_load;

	assign in_stall = clr_busy_q || (qry_vld_s1 && out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign is_hdr   = action == ACT_HEADER;
	assign is_base  = action == ACT_BASE;
	assign is_qry   = action == ACT_QUERY;

	assign hdr_ok = (alignment_class == CLASS_USABLE) &&
		(flag_value <= FLAG_LIMIT + 12'd1) &&
		({1'b0, map_quality} > ({1'b0, mqt_q} + 9'd1));

	assign base_live  = read_ok_q && (base_offset_q < len_q) &&
		(32'(base_offset_q) < 32'(READ_MAX));
	assign aligned_op = (cigar_op != CIGAR_INS) && (cigar_op != CIGAR_SOFT);
	assign ref_pos    = {1'b0, read_start_q} + 17'(aligned_count_q);
	assign qual_ok    = quality_char > (8'(bqt_q) + QUAL_OFFSET);
	assign win_lo     = 11'(lc_q) + 11'(ltrim_q);
	assign hi_sum     = 12'(base_offset_q) + 12'(rc_q) + 12'(rtrim_q);
	assign offset_inc = base_offset_q + 10'd1;
	assign rp_val     = rev_q ? len_q - offset_inc : offset_inc;
	assign tally = base_live && aligned_op && qual_ok &&
		(11'(base_offset_q) >= win_lo) && (hi_sum < 12'(len_q)) &&
		(base_code < BASE_N) && (32'(ref_pos) < 32'(POSITIONS));
	assign qry_ok = 32'(position) < 32'(POSITIONS);

	assign ram_re    = in_acc && ((is_base && tally) || (is_qry && qry_ok));
	assign ram_raddr = is_qry ? AW'(position) : AW'(ref_pos);
	assign ram_we    = clr_busy_q || base_vld_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : wr_row;

	arpt_ram #(
		.WIDTH(ROW_W),
		.DEPTH(POSITIONS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign row_rd = fwd_hit_q ? fwd_row_q : tally_row_t'(ram_rdata);

	// saturating update of one lane
	always_comb begin
		cur     = row_rd[lane_s1];
		qs_full = {1'b0, cur.qual_sum} + 41'(qadd_s1);
		rp_full = {1'b0, cur.rp_sum} + 49'(rpadd_s1);
		wr_row  = row_rd;
		wr_row[lane_s1].count    = (&cur.count) ? cur.count : cur.count + 32'd1;
		wr_row[lane_s1].qual_sum = qs_full[40] ? '1 : qs_full[39:0];
		wr_row[lane_s1].rp_sum   = rp_full[48] ? '1 : rp_full[47:0];
	end

	// consensus: first base holding the largest nonzero count
	always_comb begin
		pa_sel   = row_rd[1].count > row_rd[0].count;
		pa_cnt   = pa_sel ? row_rd[1].count : row_rd[0].count;
		pb_sel   = row_rd[3].count > row_rd[2].count;
		pb_cnt   = pb_sel ? row_rd[3].count : row_rd[2].count;
		top_sel  = pb_cnt > pa_cnt;
		best_cnt = top_sel ? pb_cnt : pa_cnt;
		best_idx = top_sel ? {1'b1, pb_sel} : {1'b0, pa_sel};
		q_cur    = row_rd[qbase_s1[1:0]];
	end

	assign out_load = qry_vld_s1 && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bqt_q   <= 6'd20;
			mqt_q   <= 8'd20;
			ltrim_q <= '0;
			rtrim_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BASE_QUAL:  bqt_q   <= cfg_data[5:0];
				REG_MAP_QUAL:   mqt_q   <= cfg_data[7:0];
				REG_LEFT_TRIM:  ltrim_q <= cfg_data;
				REG_RIGHT_TRIM: rtrim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_start_q    <= '0;
			read_ok_q       <= 1'b0;
			base_offset_q   <= '0;
			aligned_count_q <= '0;
			lc_q            <= '0;
			rc_q            <= '0;
			len_q           <= '0;
			rev_q           <= 1'b0;
		end else if (in_acc && is_hdr) begin
			read_start_q    <= position;
			read_ok_q       <= hdr_ok;
			base_offset_q   <= '0;
			aligned_count_q <= '0;
			lc_q            <= left_clip;
			rc_q            <= right_clip;
			len_q           <= read_length;
			rev_q           <= reverse_orientation;
		end else if (in_acc && is_base && base_live) begin
			base_offset_q <= offset_inc;
			if (aligned_op) begin
				aligned_count_q <= aligned_count_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(POSITIONS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_vld_s1 <= 1'b0;
			qry_vld_s1  <= 1'b0;
			fwd_hit_q   <= 1'b0;
		end else begin
			base_vld_s1 <= in_acc && is_base && tally;
			if (in_acc) begin
				qry_vld_s1 <= is_qry;
			end else if (out_load) begin
				qry_vld_s1 <= 1'b0;
			end
			if (ram_re) begin
				fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1  <= ram_raddr;
			lane_s1  <= base_code[1:0];
			qadd_s1  <= quality_char - QUAL_OFFSET;
			rpadd_s1 <= rp_val;
			qok_s1   <= qry_ok;
			qbase_s1 <= base_code;
		end
		if (ram_re) begin
			fwd_row_q <= tally_row_t'(ram_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!qok_s1) begin
				base_count_q  <= '0;
				quality_sum_q <= '0;
				rp_sum_q      <= '0;
				consensus_q   <= BASE_N;
			end else begin
				if (qbase_s1 < BASE_N) begin
					base_count_q  <= q_cur.count;
					quality_sum_q <= q_cur.qual_sum;
					rp_sum_q      <= q_cur.rp_sum;
				end else begin
					base_count_q  <= '0;
					quality_sum_q <= '0;
					rp_sum_q      <= '0;
				end
				consensus_q <= (best_cnt == '0) ? BASE_N : {1'b0, best_idx};
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign base_count        = base_count_q;
	assign quality_sum       = quality_sum_q;
	assign read_position_sum = rp_sum_q;
	assign consensus_base    = consensus_q;

`ifndef SYNTHESIS
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(clr_busy_q && base_vld_s1))
		else $error("base write-back during clearing pass");

	a_one_kind_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!(base_vld_s1 && qry_vld_s1))
		else $error("stage 1 holds a base and a query");

	a_query_held: assert property (@(posedge clk) disable iff (!arst_n)
		(qry_vld_s1 && out_valid_q && out_stall) |=> (qry_vld_s1 && out_valid_q))
		else $error("pending query lost behind stalled output");

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_hit_q) |-> $past(ram_we))
		else $error("forwarding hit without a write");
`endif

endmodule
`default_nettype wire
